// File: hdl/he_pkg.sv
package he_pkg;

  localparam int PIX_W = 8;
  localparam int CNT_W = 21;
  localparam int CMP_W = 25;
  localparam int PROD_W = CNT_W + PIX_W;
  localparam int NUM_W = 38;
  localparam int THR_W = 31;

  localparam logic CMD_HIST  = 1'b0;
  localparam logic CMD_REMAP = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_BUILD
  } ctl_state_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_MUL,
    BS_ACC,
    BS_STEP
  } bld_state_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
  } sweep_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
    logic [PIX_W-1:0] data;
  } tbl_wr_t;

endpackage

// File: hdl/he_in_if.sv
interface he_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [he_pkg::PIX_W-1:0] pixel;
  logic                     last;

  modport source(output valid, cmd, pixel, last, input ready);
  modport sink(input valid, cmd, pixel, last, output ready);
endinterface

// File: hdl/he_out_if.sv
interface he_out_if;
  logic                     valid;
  logic                     ready;
  logic [he_pkg::PIX_W-1:0] level;
  logic                     end_of_image;

  modport source(output valid, level, end_of_image, input ready);
  modport sink(input valid, level, end_of_image, output ready);
endinterface

// File: hdl/he_cfg_if.sv
interface he_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [he_pkg::PIX_W-1:0] max_level;

  modport source(output valid, max_level, input ready);
  modport sink(input valid, max_level, output ready);
endinterface

// File: hdl/he_hist.sv
module he_hist #(
  parameter int LEVELS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cnt_en,
  input  logic [$clog2(LEVELS)-1:0] cnt_idx,
  input  he_pkg::sweep_t            sweep,
  output logic [he_pkg::CNT_W-1:0]  rdata
);
  import he_pkg::*;

  localparam int IDX_W = $clog2(LEVELS);

  logic [CNT_W-1:0] mem [LEVELS];
  logic [CNT_W-1:0] rdata_r;
  logic             st1_v_r;
  logic [IDX_W-1:0] st1_idx_r;
  logic             fwd_v_r;
  logic [CNT_W-1:0] fwd_val_r;
  logic [CNT_W-1:0] inc;

  assign inc = (fwd_v_r ? fwd_val_r : rdata_r) + 1'b1;
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (sweep.en) begin
      rdata_r <= mem[sweep.addr[IDX_W-1:0]];
      mem[sweep.addr[IDX_W-1:0]] <= '0;
    end else begin
      if (cnt_en) begin
        rdata_r <= mem[cnt_idx];
      end
      if (st1_v_r) begin
        mem[st1_idx_r] <= inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      st1_v_r <= cnt_en;
      fwd_v_r <= cnt_en && st1_v_r && (st1_idx_r == cnt_idx);
    end
  end

  always_ff @(posedge clk) begin
    st1_idx_r <= cnt_idx;
    fwd_val_r <= inc;
  end

endmodule

// File: hdl/he_build.sv
module he_build #(
  parameter int LEVELS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [he_pkg::PIX_W-1:0] m,
  input  logic [he_pkg::CNT_W-1:0] n,
  input  logic [he_pkg::CNT_W-1:0] hist_rdata,
  output he_pkg::sweep_t           sweep,
  output he_pkg::tbl_wr_t          tbl_wr,
  output logic                     done
);
  import he_pkg::*;

  localparam int IDX_W = $clog2(LEVELS);
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(LEVELS - 1);

  bld_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [PIX_W-1:0]  m_r;
  logic [CNT_W:0]    two_n_r;
  logic              n_zero_r;
  logic [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]  num_r;
  logic [THR_W-1:0]  thr_r;
  logic [PIX_W-1:0]  q_r;
  logic              step_up;

  assign step_up = !n_zero_r && (q_r != m_r) && (NUM_W'(thr_r) <= num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    sweep.en    = 1'b0;
    sweep.addr  = PIX_W'(k_r);
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = PIX_W'(k_r);
    tbl_wr.data = q_r;
    done        = 1'b0;
    case (state_r)
      BS_CLEAR: begin
        sweep.en = 1'b1;
        if (k_r == K_LAST) begin
          done      = 1'b1;
          k_nxt     = '0;
          state_nxt = BS_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      BS_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          state_nxt = BS_READ;
        end
      end
      BS_READ: begin
        sweep.en  = 1'b1;
        state_nxt = BS_MUL;
      end
      BS_MUL: begin
        state_nxt = BS_ACC;
      end
      BS_ACC: begin
        state_nxt = BS_STEP;
      end
      BS_STEP: begin
        if (!step_up) begin
          tbl_wr.en = 1'b1;
          if (k_r == K_LAST) begin
            done      = 1'b1;
            k_nxt     = '0;
            state_nxt = BS_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = BS_READ;
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        m_r      <= m;
        two_n_r  <= {n, 1'b0};
        n_zero_r <= (n == '0);
        num_r    <= NUM_W'(n);
        thr_r    <= THR_W'({n, 1'b0});
        q_r      <= '0;
      end
      BS_MUL: begin
        if (PIX_W'(k_r) <= m_r) begin
          prod_r <= PROD_W'(hist_rdata * m_r);
        end else begin
          prod_r <= '0;
        end
      end
      BS_ACC: begin
        num_r <= num_r + NUM_W'({prod_r, 1'b0});
      end
      BS_STEP: begin
        if (step_up) begin
          q_r   <= q_r + 1'b1;
          thr_r <= thr_r + THR_W'(two_n_r);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/he_remap.sv
module he_remap #(
  parameter int LEVELS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [$clog2(LEVELS)-1:0] rd_idx,
  input  logic                      rd_last,
  input  logic                      table_ok,
  input  he_pkg::tbl_wr_t           tbl_wr,
  output logic                      acc_ok,
  he_out_if.source                  out_if
);
  import he_pkg::*;

  localparam int IDX_W = $clog2(LEVELS);

  logic [PIX_W-1:0] mem [LEVELS];
  logic [PIX_W-1:0] rdata_r;
  logic             r1_v_r;
  logic             r1_last_r;
  logic             r1_ok_r;
  logic             o_v_r;
  logic [PIX_W-1:0] o_level_r;
  logic             o_eoi_r;
  logic             move;

  assign move   = r1_v_r && (!o_v_r || out_if.ready);
  assign acc_ok = !r1_v_r || move;

  assign out_if.valid        = o_v_r;
  assign out_if.level        = o_level_r;
  assign out_if.end_of_image = o_eoi_r;

  always_ff @(posedge clk) begin
    if (tbl_wr.en) begin
      mem[tbl_wr.addr[IDX_W-1:0]] <= tbl_wr.data;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_idx];
      r1_last_r <= rd_last;
      r1_ok_r   <= table_ok;
    end
    if (move) begin
      o_level_r <= r1_ok_r ? rdata_r : '0;
      o_eoi_r   <= r1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      r1_v_r <= rd_en || (r1_v_r && !move);
      o_v_r  <= move || (o_v_r && !out_if.ready);
    end
  end

endmodule

// File: hdl/histogram_equalizer.sv
// Histogram pixels are taken one per cycle; a remap pixel's result passes through a table
// read register and an output register, and remap pixels also stream at one per cycle
// while the output accepts them. After the last histogram pixel the table build holds
// the input for one memory sweep: read, multiply, accumulate and a stepped rounding
// search per entry. After reset a clearing pass zeroes the histogram memory before the
// first pixel is taken; the maximum level resets to 255 and no table is valid.
module histogram_equalizer #(
  parameter int LEVELS     = 256,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic     clk,
  input  logic     rst_n,
  he_in_if.sink    in_if,
  he_out_if.source out_if,
  he_cfg_if.sink   cfg_if
);
  import he_pkg::*;

  localparam int IDX_W = $clog2(LEVELS);
  localparam logic [CMP_W-1:0] MAX_PIX = CMP_W'(MAX_PIXELS);
  localparam logic [PIX_W-1:0] TOP_LEVEL = PIX_W'(LEVELS - 1);

  ctl_state_t       state_r, state_nxt;
  logic [PIX_W-1:0] max_level_r;
  logic [CNT_W-1:0] pixel_count_r, pixel_count_nxt;
  logic             table_ready_r, table_ready_nxt;
  logic [PIX_W-1:0] m_eff;
  logic [PIX_W-1:0] pix_c;
  logic [IDX_W-1:0] idx;
  logic             acc;
  logic             hist_acc;
  logic             remap_acc;
  logic             count_en;
  logic             bld_start;
  logic             bld_done;
  logic             remap_ok;
  sweep_t           sweep;
  tbl_wr_t          tbl_wr;
  logic [CNT_W-1:0] hist_rdata;

  assign m_eff = (max_level_r > TOP_LEVEL) ? TOP_LEVEL : max_level_r;
  assign pix_c = (in_if.pixel > m_eff) ? m_eff : in_if.pixel;
  assign idx   = pix_c[IDX_W-1:0];

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_r == ST_RUN) && ((in_if.cmd == CMD_HIST) || remap_ok);

  assign acc       = in_if.valid && in_if.ready;
  assign hist_acc  = acc && (in_if.cmd == CMD_HIST);
  assign remap_acc = acc && (in_if.cmd == CMD_REMAP);
  assign count_en  = hist_acc && (CMP_W'(pixel_count_r) < MAX_PIX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      max_level_r   <= 8'd255;
      pixel_count_r <= '0;
      table_ready_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pixel_count_r <= pixel_count_nxt;
      table_ready_r <= table_ready_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        max_level_r <= cfg_if.max_level;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    table_ready_nxt = table_ready_r;
    bld_start       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (bld_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (hist_acc && in_if.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        bld_start = 1'b1;
        state_nxt = ST_BUILD;
      end
      ST_BUILD: begin
        if (bld_done) begin
          table_ready_nxt = 1'b1;
          state_nxt       = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    pixel_count_nxt = pixel_count_r;
    if (bld_start) begin
      pixel_count_nxt = '0;
    end else if (count_en) begin
      pixel_count_nxt = pixel_count_r + 1'b1;
    end
  end

  he_hist #(
    .LEVELS(LEVELS)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .cnt_en (count_en),
    .cnt_idx(idx),
    .sweep  (sweep),
    .rdata  (hist_rdata)
  );

  he_build #(
    .LEVELS(LEVELS)
  ) u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (bld_start),
    .m         (m_eff),
    .n         (pixel_count_r),
    .hist_rdata(hist_rdata),
    .sweep     (sweep),
    .tbl_wr    (tbl_wr),
    .done      (bld_done)
  );

  he_remap #(
    .LEVELS(LEVELS)
  ) u_remap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (remap_acc),
    .rd_idx  (idx),
    .rd_last (in_if.last),
    .table_ok(table_ready_r),
    .tbl_wr  (tbl_wr),
    .acc_ok  (remap_ok),
    .out_if  (out_if)
  );

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bld_done |-> (state_r == ST_BUILD || state_r == ST_CLEAR))
    else $error("table build finished outside a clear or build phase");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_acc && in_if.last) |-> ##2 (pixel_count_r == '0))
    else $error("pixel count not cleared after the last histogram pixel");

  a_table_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(table_ready_r) |-> ($past(state_r) == ST_BUILD))
    else $error("table marked ready without a completed build");

endmodule
